### rtl/dcsp_pkg.sv
// Package with the payload types, register indexes and constants of the DMX servo block.
package dcsp_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_CHANNEL_ADDRESS = 2'd0;
	localparam logic [1:0] REG_PULSE_LO        = 2'd1;
	localparam logic [1:0] REG_PULSE_HI        = 2'd2;

	// Register reset values.
	localparam logic [9:0]  CHANNEL_ADDRESS_RST = 10'd512;
	localparam logic [15:0] PULSE_LO_RST        = 16'd2000;
	localparam logic [15:0] PULSE_HI_RST        = 16'd4000;

	// Slot counter saturates here.
	localparam logic [9:0] SLOT_COUNT_MAX = 10'd1023;

	// Reciprocal for division by 10 of a 16-bit value: (x * 52429) >> 19.
	localparam logic [16:0] RECIP_DIV10  = 17'd52429;
	localparam int          SHIFT_DIV10  = 19;
	// Reciprocal for division by 255 of a value below 2^21: (x * 2105377) >> 29.
	localparam logic [21:0] RECIP_DIV255 = 22'd2105377;
	localparam int          SHIFT_DIV255 = 29;

	// Largest value of span / 10 for a 16-bit span.
	localparam logic [12:0] SPAN10_MAX = 13'd6553;

	// One received UART event.
	typedef struct packed {
		logic       break_seen;
		logic [7:0] rx_byte;
	} in_item_t;

	// One captured channel value with its servo pulse width.
	typedef struct packed {
		logic [7:0]  level;
		logic [15:0] pulse_width;
	} out_item_t;

endpackage

### rtl/dmx_channel_to_servo_pulse_core.sv
// Top level of the DMX512 single-channel receiver with servo pulse output.
//
// Each input transaction is one UART receive event (break flag and byte). A break
// restarts the slot counter; the byte after it must be a zero start code, and data
// slots are then counted from one until the slot equal to channel_address arrives.
// That slot's byte leaves as level together with the pulse width
// pulse_lo + ((level * (span / 10)) / 255) * 10, where span is pulse_hi - pulse_lo,
// or zero if pulse_hi is below pulse_lo. The block takes one transaction per clock
// cycle while the output does not stall it. The pipeline stages are: input register,
// frame decode, span multiply, reciprocal division by 255, and the output register.
// All stages advance together while the output register is empty or being taken.
// Address and pulse_lo writes take effect at once, the span in the following cycle;
// the user must see that writes are made only while no transaction is in flight;
// the block itself does not enforce it.
module dmx_channel_to_servo_pulse_core
	import dcsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	// Frame phase codes.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_BREAK = 2'd1;
	localparam logic [1:0] PH_COUNT = 2'd2;

	logic [9:0]  channel_address_q;
	logic [15:0] pulse_lo_q;
	logic [15:0] pulse_hi_q;
	logic [12:0] span10_q;

	logic [1:0]  phase_q;
	logic [9:0]  slot_count_q;

	logic        adv;
	logic        valid_s1;
	in_item_t    item_s1;
	logic        valid_s2;
	logic [7:0]  level_s2;
	logic        valid_s3;
	logic [7:0]  level_s3;
	logic [20:0] prod_s3;
	logic        valid_s4;
	logic [7:0]  level_s4;
	logic [12:0] quot_s4;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [1:0]  phase_d;
	logic [9:0]  slot_count_d;
	logic        hit;
	logic [9:0]  slot_bumped;
	logic [15:0] span;
	logic [32:0] span_prod;
	logic [42:0] div255_prod;
	logic [16:0] pulse_sum;

	// The whole pipeline moves when the output register can take a new value.
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_address_q <= CHANNEL_ADDRESS_RST;
			pulse_lo_q        <= PULSE_LO_RST;
			pulse_hi_q        <= PULSE_HI_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CHANNEL_ADDRESS: channel_address_q <= cfg_wdata[9:0];
				REG_PULSE_LO:        pulse_lo_q        <= cfg_wdata;
				REG_PULSE_HI:        pulse_hi_q        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Span divided by ten, refreshed every cycle from the configuration registers.
	assign span      = (pulse_hi_q >= pulse_lo_q) ? (pulse_hi_q - pulse_lo_q) : 16'd0;
	assign span_prod = {17'd0, span} * {16'd0, RECIP_DIV10};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span10_q <= 13'(({1'b0, PULSE_HI_RST} - {1'b0, PULSE_LO_RST}) / 17'd10);
		end else begin
			span10_q <= span_prod[SHIFT_DIV10 +: 13];
		end
	end

	// Frame decode for the item in the input register.
	assign slot_bumped = (slot_count_q != SLOT_COUNT_MAX) ? (slot_count_q + 10'd1) : slot_count_q;

	always_comb begin
		phase_d      = phase_q;
		slot_count_d = slot_count_q;
		hit          = 1'b0;
		if (item_s1.break_seen) begin
			phase_d      = PH_BREAK;
			slot_count_d = 10'd0;
		end else begin
			case (phase_q)
				PH_BREAK: begin
					phase_d      = (item_s1.rx_byte == 8'd0) ? PH_COUNT : PH_IDLE;
					slot_count_d = slot_bumped;
				end
				PH_COUNT: begin
					if (slot_count_q == channel_address_q) begin
						phase_d = PH_IDLE;
						hit     = 1'b1;
					end else begin
						slot_count_d = slot_bumped;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Frame state advances once per decoded transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			slot_count_q <= 10'd0;
		end else if (adv && valid_s1) begin
			phase_q      <= phase_d;
			slot_count_q <= slot_count_d;
		end
	end

	// Stage valid bits; only a captured slot goes on past the decode stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1 && hit;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	// Division of the product by 255 through a reciprocal multiply.
	assign div255_prod = {22'd0, prod_s3} * {21'd0, RECIP_DIV255};
	// Scale the quotient by ten with shifts and add the minimum width.
	assign pulse_sum   = {1'b0, pulse_lo_q} + {1'b0, quot_s4, 3'b000}
		+ {3'b000, quot_s4, 1'b0};

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1           <= in_data;
			level_s2          <= item_s1.rx_byte;
			level_s3          <= level_s2;
			prod_s3           <= {13'd0, level_s2} * {8'd0, span10_q};
			level_s4          <= level_s3;
			quot_s4           <= div255_prod[SHIFT_DIV255 +: 13];
			out_q.level       <= level_s4;
			out_q.pulse_width <= pulse_sum[15:0];
		end
	end

	// The quotient never exceeds the largest span over ten.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> quot_s4 <= SPAN10_MAX)
		else $error("quotient out of range");

	// A stalled input is always caused by a result waiting at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q)
		else $error("input stalled with empty output register");

	// A product stage entry only comes from a captured slot one stage earlier.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s3) |-> $past(valid_s2))
		else $error("product stage became valid without a capture");

endmodule
